>>> hdl/lowest_free_id_allocator_macros.svh
// Assertion macros shared by the checker.
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

// Implication checked on every clock edge once reset is released.
`define LFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define LFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lfa_pkg.sv
`timescale 1ns / 1ps
package lfa_pkg;
  localparam int NUM_IDS = 4096;
  localparam int ID_W = $clog2(NUM_IDS);
  localparam int WORD_W = 64;
  localparam int WIDX_W = $clog2(WORD_W);
  localparam int NUM_WORDS = NUM_IDS / WORD_W;
  localparam int ADDR_W = $clog2(NUM_WORDS);
  localparam int LEN_W = 13;

  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOC      = 2'd0;
  localparam op_t OP_ALLOC_FROM = 2'd1;
  localparam op_t OP_FIND_RUN   = 2'd2;
  localparam op_t OP_FREE       = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  // Memory access request from the controller to the bitmap store.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    word_t             wr_data;
  } mem_req_t;

  // Position of the lowest set bit of a word; found low if none.
  typedef struct packed {
    logic              found;
    logic [WIDX_W-1:0] pos;
  } pe_t;

  function automatic pe_t first_set(input word_t w);
    pe_t r;
    r.found = 1'b0;
    r.pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r.found = 1'b1;
        r.pos = WIDX_W'(i);
      end
    end
    return r;
  endfunction
endpackage

>>> hdl/lowest_free_id_allocator.sv
`timescale 1ns / 1ps
// Free reads one word; taking lowest_free rereads words to find the next one.
// A run search steps over used bits one at a time; a full map or zero run answers without a map read.
// Throughput: one request at a time; busy falls in the cycle that shows the result.
// After reset a clearing pass zeroes all 64 map words; busy is high meanwhile.
// The receiver cannot stall: out_valid is high for exactly one cycle per request.
module lowest_free_id_allocator
  import lfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_op,
  input  logic [11:0]      in_target_id,
  input  logic [12:0]      in_run_length,
  output logic             out_valid,
  output logic [11:0]      out_result_id,
  output logic             out_status
);
  mem_req_t mreq;
  word_t    rd_data;

  lfa_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .in_op, .in_target_id, .in_run_length,
    .out_valid, .out_result_id, .out_status, .mreq, .rd_data
  );

  lfa_map_ram u_ram (.clk, .req(mreq), .rd_data);
endmodule

>>> hdl/lfa_map_ram.sv
`timescale 1ns / 1ps
module lfa_map_ram
  import lfa_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output word_t    rd_data
);
  word_t mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

>>> hdl/lfa_ctrl.sv
`timescale 1ns / 1ps
module lfa_ctrl
  import lfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [ID_W-1:0]   in_target_id,
  input  logic [LEN_W-1:0]  in_run_length,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_result_id,
  output logic              out_status,
  output mem_req_t          mreq,
  input  word_t             rd_data
);
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_LRD   = 7'b0010000,
    S_LEVAL = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W:0]    addr_r, addr_nxt;
  op_t                op_r, op_nxt;
  logic [ID_W-1:0]    tid_r, tid_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [ID_W:0]      lowest_r, lowest_nxt;
  logic [ID_W:0]      rstart_r, rstart_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [ID_W-1:0]    res_r, res_nxt;
  logic               st_r, st_nxt;
  logic               ov_r, ov_nxt;
  logic [WIDX_W-1:0]  lo_r, lo_nxt;

  word_t              mask, freew, neww;
  pe_t                pe, pu;
  logic [ID_W-1:0]    hit_id;
  logic [WIDX_W:0]    nfree;
  logic [LEN_W-1:0]   need;

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_result_id = res_r;
  assign out_status = st_r;

  always_comb begin
    mask = '1 << lo_r;
    freew = ~rd_data & mask;
    pe = first_set(freew);
    hit_id = {addr_r[ADDR_W-1:0], pe.pos};
    neww = rd_data | (word_t'(1) << pe.pos);
    // First used bit at or after lo, for counting the free stretch in this word.
    pu = first_set(rd_data & mask);
    nfree = pu.found ? ((WIDX_W+1)'(pu.pos) - (WIDX_W+1)'(lo_r))
                     : ((WIDX_W+1)'(WORD_W) - (WIDX_W+1)'(lo_r));
    need = len_r - count_r;
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt = addr_r;
    op_nxt = op_r;
    tid_nxt = tid_r;
    len_nxt = len_r;
    lowest_nxt = lowest_r;
    rstart_nxt = rstart_r;
    count_nxt = count_r;
    res_nxt = res_r;
    st_nxt = st_r;
    ov_nxt = 1'b0;
    lo_nxt = lo_r;
    mreq = '0;
    mreq.rd_addr = addr_r[ADDR_W-1:0];
    mreq.wr_addr = addr_r[ADDR_W-1:0];
    case (state_r)
      S_CLEAR: begin
        mreq.wr_en = 1'b1;
        mreq.wr_data = '0;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == (ADDR_W+1)'(NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt = in_op;
          tid_nxt = in_target_id;
          len_nxt = in_run_length;
          res_nxt = '0;
          st_nxt = 1'b0;
          count_nxt = '0;
          rstart_nxt = lowest_r;
          state_nxt = S_READ;
          case (in_op)
            OP_ALLOC, OP_FIND_RUN: begin
              addr_nxt = {1'b0, lowest_r[ID_W-1:WIDX_W]};
              lo_nxt = lowest_r[WIDX_W-1:0];
              if (lowest_r[ID_W] || (in_op == OP_FIND_RUN && in_run_length == '0)) begin
                st_nxt = lowest_r[ID_W];
                res_nxt = lowest_r[ID_W] ? '0 : lowest_r[ID_W-1:0];
                state_nxt = S_DONE;
              end
            end
            OP_ALLOC_FROM, OP_FREE: begin
              addr_nxt = {1'b0, in_target_id[ID_W-1:WIDX_W]};
              lo_nxt = in_target_id[WIDX_W-1:0];
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        mreq.rd_en = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        case (op_r)
          OP_FREE: begin
            mreq.wr_en = 1'b1;
            mreq.wr_data = rd_data & ~(word_t'(1) << lo_r);
            res_nxt = tid_r;
            if ({1'b0, tid_r} < lowest_r) begin
              lowest_nxt = {1'b0, tid_r};
            end
            state_nxt = S_DONE;
          end
          OP_ALLOC, OP_ALLOC_FROM: begin
            if (pe.found) begin
              mreq.wr_en = 1'b1;
              mreq.wr_data = neww;
              res_nxt = hit_id;
              if ({1'b0, hit_id} == lowest_r) begin
                // The lowest free ID was taken: search upward for the next one.
                if (pe.pos == WIDX_W'(WORD_W - 1)) begin
                  addr_nxt = addr_r + 1'b1;
                  lo_nxt = '0;
                end else begin
                  lo_nxt = pe.pos + 1'b1;
                end
                state_nxt = S_LRD;
              end else begin
                state_nxt = S_DONE;
              end
              // The same word is re-read next unless the taken bit was its last; the write above lands first.
              if (addr_nxt == (ADDR_W+1)'(NUM_WORDS)) begin
                lowest_nxt = (ID_W+1)'(NUM_IDS);
                state_nxt = S_DONE;
              end
            end else if (addr_r == (ADDR_W+1)'(NUM_WORDS - 1)) begin
              st_nxt = 1'b1;
              state_nxt = S_DONE;
            end else begin
              addr_nxt = addr_r + 1'b1;
              lo_nxt = '0;
              state_nxt = S_READ;
            end
          end
          default: begin
            // Run search: count free bits from the run start word by word.
            if (pu.found && (LEN_W)'(nfree) < need) begin
              count_nxt = '0;
              rstart_nxt = (ID_W+1)'({addr_r[ADDR_W-1:0], pu.pos}) + 1'b1;
              lo_nxt = pu.pos + 1'b1;
              if (pu.pos == WIDX_W'(WORD_W - 1)) begin
                addr_nxt = addr_r + 1'b1;
                state_nxt = S_READ;
              end
              // Otherwise rescan the same word from just above the used bit.
              if (addr_nxt == (ADDR_W+1)'(NUM_WORDS) || pu.pos == WIDX_W'(WORD_W - 1)) begin
                if (addr_nxt == (ADDR_W+1)'(NUM_WORDS)) begin
                  st_nxt = 1'b1;
                  state_nxt = S_DONE;
                end
              end
            end else if ((LEN_W)'(nfree) >= need) begin
              res_nxt = rstart_r[ID_W-1:0];
              state_nxt = S_DONE;
            end else begin
              count_nxt = count_r + (LEN_W)'(nfree);
              lo_nxt = '0;
              addr_nxt = addr_r + 1'b1;
              if (addr_r == (ADDR_W+1)'(NUM_WORDS - 1)) begin
                st_nxt = 1'b1;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
          end
        endcase
      end
      S_LRD: begin
        mreq.rd_en = 1'b1;
        state_nxt = S_LEVAL;
      end
      S_LEVAL: begin
        if (pe.found) begin
          lowest_nxt = {1'b0, hit_id};
          state_nxt = S_DONE;
        end else if (addr_r == (ADDR_W+1)'(NUM_WORDS - 1)) begin
          lowest_nxt = (ID_W+1)'(NUM_IDS);
          state_nxt = S_DONE;
        end else begin
          addr_nxt = addr_r + 1'b1;
          lo_nxt = '0;
          state_nxt = S_LRD;
        end
      end
      S_DONE: begin
        if (st_r && op_r != OP_FREE) begin
          res_nxt = '0;
        end
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r <= '0;
      lowest_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      lowest_r <= lowest_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    tid_r <= tid_nxt;
    len_r <= len_nxt;
    rstart_r <= rstart_nxt;
    count_r <= count_nxt;
    res_r <= res_nxt;
    st_r <= st_nxt;
    lo_r <= lo_nxt;
  end
endmodule

>>> hdl/lfa_checker.sv
`timescale 1ns / 1ps
`include "lowest_free_id_allocator_macros.svh"
module lfa_checker
  import lfa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [11:0] out_result_id,
  input logic        out_status
);
  `LFA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after a request")
  `LFA_ASSERT_NXT(a_valid_single, out_valid, !out_valid, "result held for more than one cycle")
  `LFA_ASSERT_IMP(a_valid_idle, out_valid, !busy, "result shown while still busy")
  `LFA_ASSERT_IMP(a_fail_zero, out_valid && out_status, out_result_id == '0, "status flag inconsistent")
endmodule

bind lowest_free_id_allocator lfa_checker u_lfa_checker (
  .clk, .rst_n, .start, .busy,
  .out_valid, .out_result_id, .out_status
);
